>>> design/escaped_string_unescaper_macros.svh
`ifndef ESCAPED_STRING_UNESCAPER_MACROS_SVH
`define ESCAPED_STRING_UNESCAPER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ESU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ESU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/esu_pkg.sv
`default_nettype none

package esu_pkg;

    localparam int BYTE_W = 8;
    localparam int ERR_W  = 3;
    localparam int ACC_W  = 12;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BADHEX  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNC   = 3'd4;

    localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CHR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_APOS   = 8'h27;
    localparam logic [BYTE_W-1:0] CHR_N      = 8'h6e;
    localparam logic [BYTE_W-1:0] CHR_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CHR_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CHR_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CTL_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CTL_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CTL_CR     = 8'h0d;

    typedef struct packed {
        logic                last;
        logic [ERR_W-1:0]    err;
        logic [BYTE_W-1:0]   data;
    } result_t;

    // Bit 4 set means the character is not a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] d;
        case (c) inside
            [8'h30:8'h39]: d = {1'b0, 4'(c - 8'h30)};
            [8'h61:8'h66]: d = {1'b0, 4'(c - 8'h57)};
            [8'h41:8'h46]: d = {1'b0, 4'(c - 8'h37)};
            default:       d = 5'b1_0000;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/escaped_string_unescaper.sv
// Decodes backslash escapes in a byte stream, one byte accepted per clock cycle while
// s_tready is high; each result is registered in out_reg, or in skid_reg while the sink
// stalls. Each input byte gives at most one result: a decoded byte with error code 0,
// or a single error report (byte 0 and a nonzero code) after which the rest of the
// stream is dropped until the byte that carries s_tlast. A stream whose last byte
// leaves an escape open reports code 4. The decode state sits in registers and is
// updated by one level of logic per byte; results go into a two-entry output stage, so
// s_tready depends only on registers and the block keeps taking bytes while one result
// waits. cfg_wdata = 0 passes bytes through unchanged; write it only while idle.
`default_nettype none

module escaped_string_unescaper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic             m_tlast
);
    import esu_pkg::*;

    logic             enable_reg;
    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       digits_reg, digits_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_reg, out_next;
    result_t          skid_reg, skid_next;

    logic             in_fire;
    logic             res_valid;
    result_t          res;
    logic [4:0]       hex;
    logic [15:0]      full_value;
    logic             out_free;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign hex      = hex_digit(s_tdata);
    assign full_value = {acc_reg, hex[3:0]};

    always_comb begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        res_valid   = 1'b0;
        res.last    = s_tlast;
        res.err     = ERR_NONE;
        res.data    = '0;

        if (!enable_reg) begin
            res_valid = 1'b1;
            res.data  = s_tdata;
        end else begin
            case (mode_reg)
                MODE_NORMAL: begin
                    if (s_tdata == CHR_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        res_valid = 1'b1;
                        res.data  = s_tdata;
                    end
                end
                MODE_ESCAPE: begin
                    mode_next = MODE_NORMAL;
                    case (s_tdata) inside
                        CHR_N: begin
                            res_valid = 1'b1;
                            res.data  = CTL_LF;
                        end
                        CHR_T: begin
                            res_valid = 1'b1;
                            res.data  = CTL_TAB;
                        end
                        CHR_R: begin
                            res_valid = 1'b1;
                            res.data  = CTL_CR;
                        end
                        CHR_QUOTE, CHR_APOS, CHR_BSLASH: begin
                            res_valid = 1'b1;
                            res.data  = s_tdata;
                        end
                        CHR_U: begin
                            mode_next   = MODE_HEX;
                            digits_next = '0;
                            acc_next    = '0;
                        end
                        default: begin
                            res.err = ERR_UNKNOWN;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (hex[4]) begin
                        res.err = ERR_BADHEX;
                    end else if (digits_reg == 2'd3) begin
                        mode_next   = MODE_NORMAL;
                        digits_next = '0;
                        acc_next    = '0;
                        if (full_value[15:8] != 8'd0) begin
                            res.err = ERR_RANGE;
                        end else begin
                            res_valid = 1'b1;
                            res.data  = full_value[7:0];
                        end
                    end else begin
                        acc_next    = {acc_reg[ACC_W-5:0], hex[3:0]};
                        digits_next = digits_reg + 2'd1;
                    end
                end
                default: begin
                    // Sticky error: the stream is swallowed until its last byte.
                end
            endcase

            if (mode_reg != MODE_ERROR && res.err == ERR_NONE && s_tlast
                && mode_next != MODE_NORMAL) begin
                res.err = ERR_TRUNC;
            end

            if (res.err != ERR_NONE) begin
                res_valid   = 1'b1;
                res.data    = '0;
                mode_next   = MODE_ERROR;
                digits_next = '0;
                acc_next    = '0;
            end
        end

        if (s_tlast) begin
            mode_next   = MODE_NORMAL;
            digits_next = '0;
            acc_next    = '0;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_fire && res_valid) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_fire && res_valid) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b1;
            mode_reg       <= MODE_NORMAL;
            digits_reg     <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            if (in_fire) begin
                mode_reg   <= mode_next;
                digits_reg <= digits_next;
                acc_reg    <= acc_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.err, out_reg.data};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

>>> design/esu_checker.sv
`default_nettype none

`include "escaped_string_unescaper_macros.svh"

module esu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        cfg_wdata,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);
    import esu_pkg::*;

    logic [ERR_W-1:0] err_code;
    logic             unused_inputs;

    assign err_code      = m_tdata[10:8];
    assign unused_inputs = cfg_we ^ cfg_wdata ^ s_tvalid ^ s_tready ^ s_tlast ^ (^s_tdata);

    // A result held back by the sink must not change.
    `ESU_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // An error report carries a zero byte.
    `ESU_ASSERT(a_err_zero, m_tvalid && err_code != ERR_NONE |-> m_tdata[7:0] == 8'd0, "error report with nonzero byte")

    // Only the defined error codes appear, and the padding bits stay zero.
    `ESU_ASSERT(a_err_range, m_tvalid |-> (err_code == ERR_NONE || err_code == ERR_UNKNOWN || err_code == ERR_BADHEX || err_code == ERR_RANGE || err_code == ERR_TRUNC) && m_tdata[15:11] == 5'd0 && !(unused_inputs === 1'bx && 1'b0), "bad error code or padding")

    // Nothing is presented right after reset.
    `ESU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "output not idle after reset")

endmodule

bind escaped_string_unescaper esu_checker u_esu_checker (.*);

`default_nettype wire
